// ===== src/wss_pkg.sv =====
package wss_pkg;

  localparam int DAYS              = 7;
  localparam int SLOTS_PER_DAY_DEF = 96;
  localparam int SEC_PER_DAY       = 86400;
  localparam int SEC_W             = 17;
  localparam int DAY_W             = 3;
  localparam int STEP_W            = 3;

  localparam logic [SEC_W-1:0] SEC_PER_HOUR = SEC_W'(3600);
  localparam logic [SEC_W-1:0] SEC_PER_MIN  = SEC_W'(60);

  typedef enum logic [1:0] {
    KIND_APPLY   = 2'd0,
    KIND_DEFAULT = 2'd1,
    KIND_CLEAN   = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_BYTE,
    WR_NIB,
    WR_APPLY,
    WR_QUERY
  } wr_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_SWEEP,
    J_DISPATCH,
    J_OUT
  } jmp_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_CLEAR   = 3'd0;
  localparam step_t STEP_IDLE    = 3'd1;
  localparam step_t STEP_APPLY   = 3'd2;
  localparam step_t STEP_DEFAULT = 3'd3;
  localparam step_t STEP_CLEAN   = 3'd4;
  localparam step_t STEP_QUERY   = 3'd5;
  localparam step_t STEP_RESULT  = 3'd6;

  typedef struct packed {
    wr_e   wr;
    logic  adv;
    logic  init;
    logic  emit;
    jmp_e  jmp;
    step_t target;
  } uop_t;

  typedef struct packed {
    wr_e  wr;
    logic adv;
    logic init;
    logic accept;
    logic emit;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } stat_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       ans;
  } res_t;

endpackage

// ===== src/wss_seq.sv =====
module wss_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      kind_i,
  input  logic            out_free_i,
  input  wss_pkg::stat_t  stat_i,
  output wss_pkg::ctrl_t  ctrl_o
);

  wss_pkg::step_t pc_q, pc_d;
  wss_pkg::uop_t  uop;
  wss_pkg::step_t entry;

  // microprogram
  always_comb begin
    uop = '{wr: wss_pkg::WR_NONE, adv: 1'b0, init: 1'b0, emit: 1'b0,
            jmp: wss_pkg::J_NEXT, target: wss_pkg::STEP_IDLE};
    case (pc_q)
      wss_pkg::STEP_CLEAR: begin
        uop.wr = wss_pkg::WR_ZERO; uop.adv = 1'b1;
        uop.jmp = wss_pkg::J_SWEEP; uop.target = wss_pkg::STEP_IDLE;
      end
      wss_pkg::STEP_IDLE: begin
        uop.init = 1'b1; uop.jmp = wss_pkg::J_DISPATCH;
      end
      wss_pkg::STEP_APPLY: begin
        uop.wr = wss_pkg::WR_APPLY; uop.adv = 1'b1;
        uop.jmp = wss_pkg::J_SWEEP; uop.target = wss_pkg::STEP_RESULT;
      end
      wss_pkg::STEP_DEFAULT: begin
        uop.wr = wss_pkg::WR_NIB; uop.adv = 1'b1;
        uop.jmp = wss_pkg::J_SWEEP; uop.target = wss_pkg::STEP_RESULT;
      end
      wss_pkg::STEP_CLEAN: begin
        uop.wr = wss_pkg::WR_BYTE; uop.adv = 1'b1;
        uop.jmp = wss_pkg::J_SWEEP; uop.target = wss_pkg::STEP_RESULT;
      end
      wss_pkg::STEP_QUERY: begin
        uop.wr = wss_pkg::WR_QUERY; uop.adv = 1'b1;
        uop.jmp = wss_pkg::J_SWEEP; uop.target = wss_pkg::STEP_RESULT;
      end
      wss_pkg::STEP_RESULT: begin
        uop.emit = 1'b1; uop.jmp = wss_pkg::J_OUT; uop.target = wss_pkg::STEP_IDLE;
      end
      default: begin
        uop.jmp = wss_pkg::J_SWEEP; uop.target = wss_pkg::STEP_IDLE;
      end
    endcase
  end

  always_comb begin
    case (wss_pkg::kind_e'(kind_i))
      wss_pkg::KIND_APPLY:   entry = wss_pkg::STEP_APPLY;
      wss_pkg::KIND_DEFAULT: entry = wss_pkg::STEP_DEFAULT;
      wss_pkg::KIND_CLEAN:   entry = wss_pkg::STEP_CLEAN;
      wss_pkg::KIND_QUERY:   entry = wss_pkg::STEP_QUERY;
      default:               entry = wss_pkg::STEP_IDLE;
    endcase
  end

  always_comb begin
    case (uop.jmp)
      wss_pkg::J_NEXT:     pc_d = pc_q + 1'b1;
      wss_pkg::J_SWEEP:    pc_d = stat_i.last ? uop.target : pc_q;
      wss_pkg::J_DISPATCH: pc_d = in_valid_i ? entry : pc_q;
      wss_pkg::J_OUT:      pc_d = out_free_i ? uop.target : pc_q;
      default:             pc_d = wss_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= wss_pkg::STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    ctrl_o.wr     = uop.wr;
    ctrl_o.adv    = uop.adv;
    ctrl_o.init   = uop.init;
    ctrl_o.idle   = (uop.jmp == wss_pkg::J_DISPATCH);
    ctrl_o.accept = ctrl_o.idle && in_valid_i;
    ctrl_o.emit   = uop.emit && out_free_i;
  end

endmodule

// ===== src/wss_dp.sv =====
module wss_dp #(
  parameter int SLOTS_PER_DAY = wss_pkg::SLOTS_PER_DAY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wss_pkg::ctrl_t ctrl_i,
  input  logic [1:0]     kind_i,
  input  logic           program_req_i,
  input  logic [7:0]     value_i,
  input  logic [6:0]     day_mask_i,
  input  logic [4:0]     start_hour_i,
  input  logic [5:0]     start_minute_i,
  input  logic [4:0]     stop_hour_i,
  input  logic [5:0]     stop_minute_i,
  input  logic [2:0]     query_day_i,
  input  logic [4:0]     query_hour_i,
  input  logic [5:0]     query_minute_i,
  output wss_pkg::stat_t stat_o,
  output wss_pkg::res_t  res_o
);

  localparam int SEC_W  = wss_pkg::SEC_W;
  localparam int DEPTH  = wss_pkg::DAYS * SLOTS_PER_DAY;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(SLOTS_PER_DAY);
  localparam int DELTA  = wss_pkg::SEC_PER_DAY / SLOTS_PER_DAY;

  localparam logic [SEC_W-1:0]  DELTA_C     = SEC_W'(DELTA);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOTS_PER_DAY - 1);

  // latched word
  logic [1:0]                kind_q;
  logic                      prog_q;
  logic [7:0]                value_q;
  logic [6:0]                mask_q;
  logic [SEC_W-1:0]          lo_q, hi_q, qsec_q;
  logic [wss_pkg::DAY_W-1:0] qday_q;

  // sweep counters
  logic [ADDR_W-1:0]         addr_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [wss_pkg::DAY_W-1:0] day_q;
  logic [SEC_W-1:0]          t_q, t_end;
  logic                      hit_q;

  logic [3:0] lo_mem [DEPTH];
  logic [3:0] hi_mem [DEPTH];
  logic [3:0] rd_lo_q, rd_hi_q;

  logic       in_range, q_hit;
  logic       wr_lo, wr_hi, rd_en;
  logic [3:0] wlo, whi;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      kind_q  <= kind_i;
      prog_q  <= program_req_i;
      value_q <= value_i;
      mask_q  <= day_mask_i;
      lo_q    <= SEC_W'(start_hour_i) * wss_pkg::SEC_PER_HOUR
               + SEC_W'(start_minute_i) * wss_pkg::SEC_PER_MIN;
      hi_q    <= SEC_W'(stop_hour_i) * wss_pkg::SEC_PER_HOUR
               + SEC_W'(stop_minute_i) * wss_pkg::SEC_PER_MIN;
      qsec_q  <= SEC_W'(query_hour_i) * wss_pkg::SEC_PER_HOUR
               + SEC_W'(query_minute_i) * wss_pkg::SEC_PER_MIN;
      qday_q  <= query_day_i;
    end
  end

  assign t_end    = t_q + DELTA_C;
  assign in_range = mask_q[day_q] && (t_q >= lo_q) && (t_q < hi_q);
  assign q_hit    = (day_q == qday_q) && (t_q <= qsec_q) && (qsec_q < t_end);

  always_comb begin
    wr_lo = 1'b0;
    wr_hi = 1'b0;
    rd_en = 1'b0;
    wlo   = value_q[3:0];
    whi   = value_q[3:0];
    case (ctrl_i.wr)
      wss_pkg::WR_ZERO: begin
        wr_lo = 1'b1; wr_hi = 1'b1; wlo = 4'h0; whi = 4'h0;
      end
      wss_pkg::WR_BYTE: begin
        wr_lo = 1'b1; wr_hi = 1'b1; whi = value_q[7:4];
      end
      wss_pkg::WR_NIB: begin
        wr_lo = !prog_q; wr_hi = prog_q;
      end
      wss_pkg::WR_APPLY: begin
        wr_lo = !prog_q && in_range; wr_hi = prog_q && in_range;
      end
      wss_pkg::WR_QUERY: rd_en = q_hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_lo) lo_mem[addr_q] <= wlo;
    if (wr_hi) hi_mem[addr_q] <= whi;
    if (rd_en) begin
      rd_lo_q <= lo_mem[addr_q];
      rd_hi_q <= hi_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      slot_q <= '0;
      day_q  <= '0;
      t_q    <= '0;
      hit_q  <= 1'b0;
    end else if (ctrl_i.init) begin
      addr_q <= '0;
      slot_q <= '0;
      day_q  <= '0;
      t_q    <= '0;
      hit_q  <= 1'b0;
    end else if (ctrl_i.adv) begin
      addr_q <= addr_q + 1'b1;
      if (rd_en) hit_q <= 1'b1;
      if (slot_q == LAST_SLOT) begin
        slot_q <= '0;
        day_q  <= day_q + 1'b1;
        t_q    <= '0;
      end else begin
        slot_q <= slot_q + 1'b1;
        t_q    <= t_end;
      end
    end
  end

  assign stat_o.last = (addr_q == LAST_ADDR);
  assign res_o.ans   = (wss_pkg::kind_e'(kind_q) == wss_pkg::KIND_QUERY);
  assign res_o.idx   = (res_o.ans && hit_q) ? (prog_q ? rd_hi_q : rd_lo_q) : 4'h0;

endmodule

// ===== src/weekly_setpoint_schedule.sv =====
// Flow: a word is accepted in the idle step, the microprogram sweeps all
// 7*SLOTS_PER_DAY slots one per cycle, then the result step registers the word
// into the output register, waiting in that step while the output is stalled.
// A new word is taken only after the result step has handed the last one on.
// Reset: a clearing pass writes zero to all 7*SLOTS_PER_DAY slots, with
// in_stall_o high, before the first word is taken.
module weekly_setpoint_schedule #(
  parameter int SLOTS_PER_DAY = wss_pkg::SLOTS_PER_DAY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic       program_req_i,
  input  logic [7:0] value_i,
  input  logic [6:0] day_mask_i,
  input  logic [4:0] start_hour_i,
  input  logic [5:0] start_minute_i,
  input  logic [4:0] stop_hour_i,
  input  logic [5:0] stop_minute_i,
  input  logic [2:0] query_day_i,
  input  logic [4:0] query_hour_i,
  input  logic [5:0] query_minute_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] setpoint_index_o,
  output logic       is_answer_o
);

  wss_pkg::ctrl_t ctrl;
  wss_pkg::stat_t stat;
  wss_pkg::res_t  res;

  logic       out_vld_q;
  logic [3:0] idx_q;
  logic       ans_q;
  logic       out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  wss_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wss_dp #(
    .SLOTS_PER_DAY (SLOTS_PER_DAY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .kind_i         (kind_i),
    .program_req_i  (program_req_i),
    .value_i        (value_i),
    .day_mask_i     (day_mask_i),
    .start_hour_i   (start_hour_i),
    .start_minute_i (start_minute_i),
    .stop_hour_i    (stop_hour_i),
    .stop_minute_i  (stop_minute_i),
    .query_day_i    (query_day_i),
    .query_hour_i   (query_hour_i),
    .query_minute_i (query_minute_i),
    .stat_o         (stat),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      idx_q <= res.idx;
      ans_q <= res.ans;
    end
  end

  assign in_stall_o       = !ctrl.idle;
  assign out_valid_o      = out_vld_q;
  assign setpoint_index_o = idx_q;
  assign is_answer_o      = ans_q;

endmodule
